>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Command and result item types for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_TAKE   = 2'd1,
      KIND_GIVE   = 2'd2,
      KIND_DELETE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_PARAM   = 3'd1,
      ST_UNAVAIL = 3'd2,
      ST_HANDLE  = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_BLOCKED = 3'd5
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [3:0]  task_id;
      logic [7:0]  start_count;
      logic [7:0]  ceiling_count;
      logic        may_wait;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  new_slot;
      logic [3:0]  woken_task;
      logic        woken_valid;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/core/counting_semaphore_table_top.sv
// Flow: an accepted item is registered with its slot memory read, then its result is
// written to the output register; a give that releases a waiter and a delete with waiters
// also read the wait queue memory, and a delete gives one result per waiter.
// req_stall is high until the item is done: no new item is taken while one is in flight.
// Reset: synchronous; clears the slot-in-use flags, the sequencer and the output valid
// flag. Slot and wait queue memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// counting_semaphore_table_top
// Table of counting semaphores with a FIFO wait queue per slot. Slot state and
// queues sit in two synchronous memories; a small sequencer reads, updates and
// writes back one slot per command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module counting_semaphore_table_top import cst_pkg::*; #(
   parameter int SEM_SLOTS    = 8,
   parameter int WAITERS      = 16,
   parameter int TASK_ID_BITS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SLOT_BITS = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
   localparam int POS_BITS  = (WAITERS > 1) ? $clog2(WAITERS) : 1;
   localparam int LEN_BITS  = $clog2(WAITERS + 1);
   localparam int SUM_BITS  = LEN_BITS + 1;
   localparam int QDEPTH    = SEM_SLOTS * WAITERS;
   localparam int QA_BITS   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int TQ_BITS   = (TASK_ID_BITS < 4) ? TASK_ID_BITS : 4;

   typedef struct packed {
      logic [7:0]          count;
      logic [7:0]          limit;
      logic [POS_BITS-1:0] head;
      logic [LEN_BITS-1:0] len;
   } slot_entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_POP
   } state_type;

   state_type                state_ff, state_in;
   req_type                  cmd_ff, cmd_in;
   logic [LEN_BITS-1:0]      idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [SEM_SLOTS-1:0]     in_use_ff, in_use_in;

   slot_entry_type           slot_mem [SEM_SLOTS];
   slot_entry_type           slot_rd_ff;
   logic                     slot_we;
   logic [SLOT_BITS-1:0]     slot_waddr;
   slot_entry_type           slot_wdata;

   logic [TQ_BITS-1:0]       queue_mem [QDEPTH];
   logic [TQ_BITS-1:0]       queue_rd_ff;
   logic                     q_re;
   logic [QA_BITS-1:0]       q_raddr;
   logic                     q_we;
   logic [QA_BITS-1:0]       q_waddr;

   logic                     accept;
   logic                     out_free;
   logic [SLOT_BITS-1:0]     cmd_idx;
   logic                     handle_ok;
   logic                     free_found;
   logic [SLOT_BITS-1:0]     free_idx;
   logic [LEN_BITS-1:0]      idx_next;
   logic [SUM_BITS-1:0]      head_inc;
   logic                     emit;
   rsp_type                  res;

   // Queue address of entry i of slot s, counted from the head
   function automatic logic [QA_BITS-1:0] qaddr(input logic [SLOT_BITS-1:0] s,
                                                input logic [POS_BITS-1:0]  head,
                                                input logic [LEN_BITS-1:0]  i);
      logic [SUM_BITS-1:0] sum;
      logic [QA_BITS-1:0]  base;
      sum = SUM_BITS'(head) + SUM_BITS'(i);
      if (sum >= SUM_BITS'(WAITERS)) begin
         sum = sum - SUM_BITS'(WAITERS);
      end
      base = QA_BITS'(s) * QA_BITS'(WAITERS);
      return base + QA_BITS'(sum);
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cmd_idx   = SLOT_BITS'(cmd_ff.slot);
   assign handle_ok = (int'(cmd_ff.slot) < SEM_SLOTS) && in_use_ff[cmd_idx];
   assign idx_next  = idx_ff + LEN_BITS'(1);
   assign head_inc  = SUM_BITS'(slot_rd_ff.head) + SUM_BITS'(1);

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = accept ? req_data : cmd_ff;
      idx_in       = idx_ff;
      in_use_in    = in_use_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      slot_we      = 1'b0;
      slot_waddr   = cmd_idx;
      slot_wdata   = slot_rd_ff;
      q_re         = 1'b0;
      q_raddr      = qaddr(cmd_idx, slot_rd_ff.head, '0);
      q_we         = 1'b0;
      q_waddr      = qaddr(cmd_idx, slot_rd_ff.head, slot_rd_ff.len);
      emit         = 1'b0;
      res          = '{status: ST_OK, new_slot: 3'd0, woken_task: 4'd0,
                       woken_valid: 1'b0, last: 1'b1};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            // hold the whole update until the output register can take the item
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (cmd_ff.kind == KIND_CREATE) begin
                  if (cmd_ff.ceiling_count == 8'd0 ||
                      cmd_ff.start_count > cmd_ff.ceiling_count) begin
                     res.status = ST_PARAM;
                  end else if (!free_found) begin
                     res.status = ST_UNAVAIL;
                  end else begin
                     in_use_in[free_idx] = 1'b1;
                     slot_we          = 1'b1;
                     slot_waddr       = free_idx;
                     slot_wdata.count = cmd_ff.start_count;
                     slot_wdata.limit = cmd_ff.ceiling_count;
                     slot_wdata.head  = '0;
                     slot_wdata.len   = '0;
                     res.new_slot     = 3'(free_idx);
                  end
               end else if (!handle_ok) begin
                  res.status = ST_HANDLE;
               end else begin
                  case (cmd_ff.kind)
                     KIND_TAKE: begin
                        if (slot_rd_ff.count != 8'd0) begin
                           slot_we          = 1'b1;
                           slot_wdata.count = slot_rd_ff.count - 8'd1;
                        end else if (!cmd_ff.may_wait) begin
                           res.status = ST_TIMEOUT;
                        end else if (int'(slot_rd_ff.len) >= WAITERS) begin
                           res.status = ST_UNAVAIL;
                        end else begin
                           q_we           = 1'b1;
                           slot_we        = 1'b1;
                           slot_wdata.len = slot_rd_ff.len + LEN_BITS'(1);
                           res.status     = ST_BLOCKED;
                        end
                     end
                     KIND_GIVE: begin
                        if (slot_rd_ff.count >= slot_rd_ff.limit) begin
                           res.status = ST_UNAVAIL;
                        end else if (slot_rd_ff.len != '0) begin
                           // fetch the oldest waiter first
                           emit     = 1'b0;
                           q_re     = 1'b1;
                           state_in = S_POP;
                        end else begin
                           slot_we          = 1'b1;
                           slot_wdata.count = slot_rd_ff.count + 8'd1;
                        end
                     end
                     KIND_DELETE: begin
                        if (slot_rd_ff.len == '0) begin
                           in_use_in[cmd_idx] = 1'b0;
                        end else begin
                           emit     = 1'b0;
                           q_re     = 1'b1;
                           idx_in   = '0;
                           state_in = S_POP;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         S_POP: begin
            if (out_free) begin
               emit            = 1'b1;
               res.woken_task  = 4'(queue_rd_ff);
               res.woken_valid = 1'b1;
               if (cmd_ff.kind == KIND_GIVE) begin
                  slot_we         = 1'b1;
                  slot_wdata.head = (head_inc == SUM_BITS'(WAITERS)) ?
                                    '0 : POS_BITS'(head_inc);
                  slot_wdata.len  = slot_rd_ff.len - LEN_BITS'(1);
                  state_in        = S_IDLE;
               end else if (idx_next == slot_rd_ff.len) begin
                  in_use_in[cmd_idx] = 1'b0;
                  state_in           = S_IDLE;
               end else begin
                  // advance to the next waiter, one read per result
                  res.last = 1'b0;
                  idx_in   = idx_next;
                  q_re     = 1'b1;
                  q_raddr  = qaddr(cmd_idx, slot_rd_ff.head, idx_next);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   // Reads are issued only on accept, writes only in later states: no overlap
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (accept) begin
         slot_rd_ff <= slot_mem[SLOT_BITS'(req_data.slot)];
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= TQ_BITS'(cmd_ff.task_id);
      end
      if (q_re) begin
         queue_rd_ff <= queue_mem[q_raddr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         in_use_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         in_use_ff    <= in_use_in;
      end
   end

   `ASSERT_NEXT(a_accept_look, clock, reset, accept, state_ff == S_LOOK)
   `ASSERT_IMPLY(a_pop_has_waiter, clock, reset, state_ff == S_POP, slot_rd_ff.len != '0)
   `ASSERT_IMPLY(a_push_room, clock, reset, q_we, int'(slot_rd_ff.len) < WAITERS)
   `ASSERT_IMPLY(a_woken_ok, clock, reset, rsp_valid_ff && rsp_data_ff.woken_valid,
                 rsp_data_ff.status == ST_OK)
   `ASSERT_IMPLY(a_more_is_wake, clock, reset, rsp_valid_ff && !rsp_data_ff.last,
                 rsp_data_ff.woken_valid && cmd_ff.kind == KIND_DELETE)

endmodule
